// ===== design/tld_pkg.sv =====
// Shared types, constants and the arctangent table for the tilt level detector.
`timescale 1ns / 1ps
package tld_pkg;
    localparam int ANGLE_FRAC_BITS_DEF = 8;
    localparam int CORDIC_ITERATIONS_DEF = 16;
    localparam int TAB_DEPTH = 24;

    localparam logic [11:0] THRESHOLD_RST = 12'd256;
    localparam logic [14:0] MAX_ANGLE_RST = 15'd11520;
    localparam logic [15:0] MIN_MAG_RST = 16'd16;

    localparam logic [1:0] REG_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_MAX_ANGLE = 2'd1;
    localparam logic [1:0] REG_MIN_MAG = 2'd2;

    localparam logic       REQ_MEASURE = 1'b0;
    localparam logic       REQ_CALIBRATE = 1'b1;

    localparam logic [1:0] EV_CHANGED = 2'd0;
    localparam logic [1:0] EV_LEVEL = 2'd1;
    localparam logic [1:0] EV_TILT = 2'd2;
    localparam logic [1:0] EV_CAL = 2'd3;

    // Square root operand: up to 35 bits of sum shifted left 16.
    localparam int SQ_W = 52;
    localparam int RT_W = 26;
    // CORDIC datapath width: y up to 2^23, x up to ~2^25, gain 1.65.
    localparam int CD_W = 28;
    localparam int Z_W = 24;

    typedef struct packed {
        logic [11:0] threshold;
        logic [14:0] max_angle;
        logic [15:0] min_mag;
    } t_cfg;

    typedef struct packed {
        logic        start;
        logic [SQ_W-1:0] operand;
    } t_sqrt_req;

    function automatic logic [Z_W-1:0] atan_entry(input logic [4:0] idx);
        logic [Z_W-1:0] v;
        case (idx)
            5'd0: v = 24'd2949120;  5'd1: v = 24'd1740967;
            5'd2: v = 24'd919879;   5'd3: v = 24'd466945;
            5'd4: v = 24'd234379;   5'd5: v = 24'd117304;
            5'd6: v = 24'd58666;    5'd7: v = 24'd29335;
            5'd8: v = 24'd14668;    5'd9: v = 24'd7334;
            5'd10: v = 24'd3667;    5'd11: v = 24'd1833;
            5'd12: v = 24'd917;     5'd13: v = 24'd458;
            5'd14: v = 24'd229;     5'd15: v = 24'd115;
            5'd16: v = 24'd57;      5'd17: v = 24'd29;
            5'd18: v = 24'd14;      5'd19: v = 24'd7;
            5'd20: v = 24'd4;       5'd21: v = 24'd2;
            5'd22: v = 24'd1;
            default: v = '0;
        endcase
        return v;
    endfunction
endpackage

// ===== design/tld_if.sv =====
// Valid/ready channel carrying one item of a given payload type.
`timescale 1ns / 1ps
interface tld_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== design/tld_sqrt.sv =====
// Bit-serial integer square root, one result bit per cycle.
`timescale 1ns / 1ps
module tld_sqrt import tld_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_sqrt_req       i_req,
    output logic            o_done,
    output logic [RT_W-1:0] o_root
);
    logic [SQ_W-1:0] r_rem, n_rem;
    logic [RT_W-1:0] r_root, n_root;
    logic [4:0]      r_cnt, n_cnt;
    logic            r_busy, n_busy;
    logic [RT_W+1:0] trial;
    logic [RT_W+1:0] top;

    // Classic restoring digit method on bit pairs from the top.
    always_comb begin
        n_rem = r_rem;
        n_root = r_root;
        n_cnt = r_cnt;
        n_busy = r_busy;
        top = '0;
        trial = '0;
        if (i_req.start) begin
            n_rem = i_req.operand;
            n_root = '0;
            n_cnt = 5'(RT_W - 1);
            n_busy = 1'b1;
        end else if (r_busy) begin
            top = (RT_W+2)'(r_rem >> (2 * r_cnt));
            trial = {r_root, 2'b01};
            if (top >= trial) begin
                n_rem = r_rem - (SQ_W'(trial) << (2 * r_cnt));
                n_root = {r_root[RT_W-2:0], 1'b1};
            end else begin
                n_root = {r_root[RT_W-2:0], 1'b0};
            end
            if (r_cnt == '0) n_busy = 1'b0;
            else n_cnt = r_cnt - 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_root <= n_root;
        r_cnt <= n_cnt;
        if (!i_rst_n) r_busy <= 1'b0;
        else r_busy <= n_busy;
    end

    assign o_done = r_busy && (r_cnt == '0);
    assign o_root = (o_done) ? n_root : r_root;
endmodule

// ===== design/tld_cordic.sv =====
// Vectoring CORDIC arctangent, one micro-rotation per cycle.
`timescale 1ns / 1ps
module tld_cordic import tld_pkg::*; #(
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
    parameter int CORDIC_ITERATIONS = CORDIC_ITERATIONS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic signed [CD_W-1:0] i_y,
    input  logic signed [CD_W-1:0] i_x,
    output logic                   o_done,
    output logic signed [15:0]     o_angle
);
    localparam int ITERS = (CORDIC_ITERATIONS < TAB_DEPTH) ? CORDIC_ITERATIONS : TAB_DEPTH;
    localparam int SHR = 16 - ANGLE_FRAC_BITS;

    logic signed [CD_W-1:0] r_x, r_y, n_x, n_y;
    logic signed [Z_W:0]    r_z, n_z;
    logic [4:0]             r_i, n_i;
    logic                   r_busy, n_busy;
    logic signed [CD_W-1:0] xs, ys;
    logic signed [Z_W:0]    a, zr;

    always_comb begin
        n_x = r_x; n_y = r_y; n_z = r_z; n_i = r_i; n_busy = r_busy;
        xs = r_x >>> r_i;
        ys = r_y >>> r_i;
        a = signed'({1'b0, atan_entry(r_i)});
        if (i_start) begin
            n_x = i_x; n_y = i_y; n_z = '0; n_i = '0; n_busy = 1'b1;
        end else if (r_busy) begin
            if (r_y < 0) begin
                n_x = r_x - ys; n_y = r_y + xs; n_z = r_z - a;
            end else begin
                n_x = r_x + ys; n_y = r_y - xs; n_z = r_z + a;
            end
            if (r_i == 5'(ITERS - 1)) n_busy = 1'b0;
            else n_i = r_i + 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x <= n_x; r_y <= n_y; r_z <= n_z; r_i <= n_i;
        if (!i_rst_n) r_busy <= 1'b0;
        else r_busy <= n_busy;
    end

    assign o_done = r_busy && (r_i == 5'(ITERS - 1));
    assign zr = n_z + (Z_W+1)'(1 << (SHR - 1));
    assign o_angle = 16'(zr >>> SHR);
endmodule

// ===== design/tilt_level_detector.sv =====
// Top level: sequencer around one shared square root and one CORDIC unit.
// A measure above the floor runs three square roots and two CORDIC passes, a calibration
// above it two square roots and two CORDIC passes; below the floor a measure waits on one
// square root and a calibration on none. One item is taken at a time and held through output
// stalls. Reset (synchronous, active low) restores register defaults and clears offsets,
// last results and the level history.
`timescale 1ns / 1ps
module tilt_level_detector import tld_pkg::*; #(
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
    parameter int CORDIC_ITERATIONS = CORDIC_ITERATIONS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    tld_if.sink         i_in,
    tld_if.source       o_out
);
    localparam logic [3:0] S_IDLE = 4'd0, S_SQ = 4'd1, S_CMP = 4'd2, S_SQH = 4'd3,
                           S_CP = 4'd4, S_SQV = 4'd5, S_CR = 4'd6, S_APPLY = 4'd7,
                           S_SQM = 4'd8, S_FIN = 4'd9, S_OUT = 4'd10;

    t_cfg r_cfg;
    logic [3:0] r_st;
    logic r_req;
    logic signed [15:0] r_ax, r_ay, r_az;
    logic [31:0] r_sxx, r_syy, r_szz;
    logic [34:0] r_sum;
    logic signed [15:0] r_rp, r_rr, r_op, r_or, r_lp, r_lr, r_cp, r_cr;
    logic [15:0] r_lm;
    logic r_lv;
    logic [1:0] r_ev;
    t_sqrt_req sq_req;
    logic sq_done, cd_start, cd_done;
    logic [RT_W-1:0] sq_root;
    logic signed [CD_W-1:0] cd_y, cd_x;
    logic signed [15:0] cd_angle;
    logic signed [16:0] dp, dr, lim, cp, cr;
    logic [31:0] min2;
    logic lvl;

    assign pready = 1'b1;
    always_comb begin
        case (paddr[3:2])
            REG_THRESHOLD: prdata = 32'(r_cfg.threshold);
            REG_MAX_ANGLE: prdata = 32'(r_cfg.max_angle);
            REG_MIN_MAG: prdata = 32'(r_cfg.min_mag);
            default: prdata = '0;
        endcase
    end

    tld_sqrt u_sqrt (.i_clk, .i_rst_n, .i_req(sq_req), .o_done(sq_done), .o_root(sq_root));
    tld_cordic #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .CORDIC_ITERATIONS(CORDIC_ITERATIONS))
        u_cordic (.i_clk, .i_rst_n, .i_start(cd_start), .i_y(cd_y), .i_x(cd_x),
                  .o_done(cd_done), .o_angle(cd_angle));

    always_comb begin
        sq_req.start = 1'b0;
        sq_req.operand = '0;
        case (r_st)
            S_CMP: begin
                sq_req.start = 1'b1;
                sq_req.operand = SQ_W'(r_sxx + r_szz) << 16;
            end
            S_CP: begin
                sq_req.start = 1'b1;
                sq_req.operand = SQ_W'(r_syy + r_szz) << 16;
            end
            S_APPLY: begin
                sq_req.start = 1'b1;
                sq_req.operand = SQ_W'(dp * dp) + SQ_W'(dr * dr);
            end
            default: ;
        endcase
    end

    assign cd_start = (r_st == S_SQH && sq_done) || (r_st == S_SQV && sq_done);
    assign cd_y = (r_st == S_SQH) ? CD_W'(r_ay) <<< 8 : CD_W'(r_ax) <<< 8;
    assign cd_x = CD_W'(sq_root);

    assign lim = 17'(r_cfg.max_angle);
    assign cp = 17'(r_rp) - 17'(r_op);
    assign cr = 17'(r_rr) - 17'(r_or);
    assign dp = (cp < -lim) ? -lim : (cp > lim) ? lim : cp;
    assign dr = (cr < -lim) ? -lim : (cr > lim) ? lim : cr;
    assign min2 = r_cfg.min_mag * r_cfg.min_mag;
    assign lvl = ((sq_root[25:16] != '0) ? 16'hFFFF : sq_root[15:0]) <= 16'(r_cfg.threshold);

    assign i_in.ready = (r_st == S_IDLE);
    assign o_out.valid = (r_st == S_OUT);
    assign o_out.data.pitch_angle = r_lp;
    assign o_out.data.roll_angle = r_lr;
    assign o_out.data.tilt_magnitude = r_lm;
    assign o_out.data.level_flag = r_lv;
    assign o_out.data.event_code = r_ev;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{THRESHOLD_RST, MAX_ANGLE_RST, MIN_MAG_RST};
            r_st <= S_IDLE;
            r_op <= '0; r_or <= '0; r_lp <= '0; r_lr <= '0; r_lm <= '0; r_lv <= 1'b0;
            r_ev <= EV_CHANGED;
        end else begin
            if (psel && penable && pwrite) begin
                case (paddr[3:2])
                    REG_THRESHOLD: r_cfg.threshold <= pwdata[11:0];
                    REG_MAX_ANGLE: r_cfg.max_angle <= pwdata[14:0];
                    REG_MIN_MAG: r_cfg.min_mag <= pwdata[15:0];
                    default: ;
                endcase
            end
            case (r_st)
                S_IDLE: if (i_in.valid) begin
                    r_req <= i_in.data.req_type;
                    r_ax <= i_in.data.accel_x; r_ay <= i_in.data.accel_y;
                    r_az <= i_in.data.accel_z;
                    r_st <= S_SQ;
                end
                S_SQ: begin
                    r_sxx <= 32'(r_ax * r_ax); r_syy <= 32'(r_ay * r_ay);
                    r_szz <= 32'(r_az * r_az);
                    r_st <= S_CMP;
                end
                S_CMP: begin
                    r_sum <= 35'(r_sxx) + 35'(r_syy) + 35'(r_szz);
                    r_st <= S_SQH;
                end
                S_SQH: begin
                    // A zero or sub-floor vector skips both arctangents.
                    if (r_sum < 35'(min2) || r_sum == '0) begin
                        r_rp <= '0; r_rr <= '0; r_st <= S_APPLY;
                    end else if (sq_done) r_st <= S_CP;
                end
                S_CP: if (cd_done) begin
                    r_rp <= cd_angle; r_st <= S_SQV;
                end
                S_SQV: if (sq_done) r_st <= S_CR;
                S_CR: if (cd_done) begin
                    r_rr <= -cd_angle; r_st <= S_APPLY;
                end
                S_APPLY: begin
                    if (r_req == REQ_CALIBRATE) begin
                        r_op <= r_rp; r_or <= r_rr; r_ev <= EV_CAL; r_st <= S_OUT;
                    end else begin
                        r_cp <= 16'(dp); r_cr <= 16'(dr); r_st <= S_SQM;
                    end
                end
                S_SQM: if (sq_done) begin
                    r_lp <= r_cp; r_lr <= r_cr;
                    r_lm <= (sq_root[25:16] != '0) ? 16'hFFFF : sq_root[15:0];
                    r_lv <= lvl;
                    r_ev <= (lvl && !r_lv) ? EV_LEVEL : (!lvl && r_lv) ? EV_TILT : EV_CHANGED;
                    r_st <= S_OUT;
                end
                S_OUT: if (o_out.ready) r_st <= S_IDLE;
                default: r_st <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTH
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st != S_IDLE) |-> !i_in.ready) else $error("input taken while busy");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |=> (o_out.valid && $stable(o_out.data)))
        else $error("result changed while stalled");
    a_cal_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_APPLY && r_req == REQ_CALIBRATE) |=> (r_ev == EV_CAL))
        else $error("calibration event code wrong");
`endif
endmodule
